[rtl/dag_edge_store_with_cycle_check_assert.svh]
// Assertion macros shared by the checker of the graph edge store.
`ifndef DAG_EDGE_STORE_WITH_CYCLE_CHECK_ASSERT_SVH
`define DAG_EDGE_STORE_WITH_CYCLE_CHECK_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define DES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/des_pkg.sv]
// Package with the constants, command codes and control types of the graph edge store.
package des_pkg;
  localparam int MaxVertices = 16;
  localparam int VidW = 4;
  localparam int CntW = 5;

  typedef enum logic [3:0] {
    CMD_ADD_VERTEX  = 4'd0,
    CMD_DEL_VERTEX  = 4'd1,
    CMD_ADD_EDGE    = 4'd2,
    CMD_DEL_EDGE    = 4'd3,
    CMD_REV_EDGE    = 4'd4,
    CMD_CLEAR       = 4'd5,
    CMD_CLR_VEDGES  = 4'd6,
    CMD_CLR_EDGES   = 4'd7,
    CMD_TEST_VERTEX = 4'd8
  } cmd_e;

  typedef logic [MaxVertices-1:0] row_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;      // capture the item
    logic       exec;      // run the simple command, or the edge checks
    logic       peel_init; // start a peel pass
    logic       peel_step; // one peel round
    logic       finish;    // commit the add or revert, write the result
  } des_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_peel;  // edge checks passed and a cycle check is needed
    logic peel_done;  // no further vertex can be peeled
  } des_sts_t;
endpackage

[rtl/des_datapath.sv]
// Datapath of the graph edge store: graph state, edge checks and peel unit.
module des_datapath
  import des_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  des_cmd_t       cmd_i,
  output des_sts_t       sts_o,
  input  logic [3:0]     command_i,
  input  logic [VidW-1:0] from_vertex_i,
  input  logic [VidW-1:0] to_vertex_i,
  input  logic           acyclic_only_i,
  input  logic [CntW-1:0] max_out_edges_i,
  output logic           ok_o,
  output logic [VidW-1:0] new_vertex_o
);
  row_t             present_q, present_d;
  row_t             rows_q [MaxVertices];
  row_t             rows_d [MaxVertices];
  row_t             marked_q, marked_d;
  logic [3:0]       cmd_q;
  logic [VidW-1:0]  f_q, t_q;
  logic [VidW-1:0]  af_q, af_d, at_q, at_d; // edge under test
  logic             pend_q, pend_d;          // add checks passed, awaiting peel
  logic             rev_q, rev_d;            // reverse: restore f->t on failure
  logic             ok_q, ok_d;
  logic [VidW-1:0]  nv_q, nv_d;
  logic             peel_done;
  logic [VidW-1:0]  peel_v;
  logic             peel_found;
  logic             chk_ok;
  logic [CntW-1:0]  deg;
  logic [VidW-1:0]  deg_v;
  logic [VidW-1:0]  hi_id;
  logic             any_present;
  logic             add_fail_now;

  // Source of the edge that an add or a reverse would create.
  assign deg_v = (cmd_q == CMD_REV_EDGE) ? t_q : f_q;

  // Out-degree of the source of the tested edge.
  always_comb begin
    deg = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      deg = deg + CntW'(rows_q[deg_v][i]);
    end
  end

  // Highest present vertex.
  always_comb begin
    hi_id = '0;
    any_present = 1'b0;
    for (int i = 0; i < MaxVertices; i++) begin
      if (present_q[i]) begin
        hi_id = VidW'(i);
        any_present = 1'b1;
      end
    end
  end

  // Lowest peelable vertex.
  always_comb begin
    peel_v = '0;
    peel_found = 1'b0;
    for (int i = MaxVertices-1; i >= 0; i--) begin
      if (present_q[i] && !marked_q[i] && ((rows_q[i] & ~marked_q) == '0)) begin
        peel_v = VidW'(i);
        peel_found = 1'b1;
      end
    end
  end
  assign peel_done = !peel_found;

  always_comb begin
    present_d = present_q;
    rows_d = rows_q;
    marked_d = marked_q;
    af_d = af_q;
    at_d = at_q;
    pend_d = 1'b0;
    rev_d = rev_q;
    ok_d = ok_q;
    nv_d = nv_q;
    chk_ok = 1'b0;
    add_fail_now = 1'b0;
    if (cmd_i.exec) begin
      ok_d = 1'b0;
      nv_d = '0;
      rev_d = 1'b0;
      af_d = f_q;
      at_d = t_q;
      case (cmd_q)
        CMD_ADD_VERTEX: begin
          if (!(any_present && hi_id == VidW'(MaxVertices-1))) begin
            af_d = any_present ? hi_id + VidW'(1) : '0;
            present_d[af_d] = 1'b1;
            rows_d[af_d] = '0;
            ok_d = 1'b1;
            nv_d = af_d;
          end
        end
        CMD_DEL_VERTEX: begin
          if (present_q[f_q]) begin
            for (int i = 0; i < MaxVertices; i++) begin
              rows_d[i][f_q] = 1'b0;
            end
            rows_d[f_q] = '0;
            present_d[f_q] = 1'b0;
            ok_d = 1'b1;
          end
        end
        CMD_DEL_EDGE: begin
          if (present_q[f_q] && present_q[t_q] && rows_q[f_q][t_q]) begin
            rows_d[f_q][t_q] = 1'b0;
            ok_d = 1'b1;
          end
        end
        CMD_ADD_EDGE, CMD_REV_EDGE: begin
          if (cmd_q == CMD_REV_EDGE) begin
            af_d = t_q;
            at_d = f_q;
          end
          if (present_q[f_q] && present_q[t_q] &&
              (cmd_q == CMD_ADD_EDGE || rows_q[f_q][t_q])) begin
            // For reverse, the from->to edge is removed first; this only
            // changes the degree and existence of to->from if f equals t.
            chk_ok = 1'b1;
            if (cmd_q == CMD_REV_EDGE) begin
              rows_d[f_q][t_q] = 1'b0;
              rev_d = 1'b1;
              if (f_q == t_q) begin
                // Self edge: after removal it is absent, degree one less.
                chk_ok = !(max_out_edges_i != '0 &&
                           (deg - CntW'(1)) >= max_out_edges_i) && !acyclic_only_i;
              end else begin
                chk_ok = !(max_out_edges_i != '0 && deg >= max_out_edges_i) &&
                         !rows_q[af_d][at_d];
              end
            end else begin
              chk_ok = !(max_out_edges_i != '0 && deg >= max_out_edges_i) &&
                       !rows_q[af_d][at_d] && !(acyclic_only_i && f_q == t_q);
            end
            if (chk_ok) begin
              if (acyclic_only_i) begin
                pend_d = 1'b1;
              end else begin
                rows_d[af_d][at_d] = 1'b1;
                ok_d = 1'b1;
              end
            end else begin
              add_fail_now = 1'b1;
            end
          end
        end
        CMD_CLEAR: begin
          present_d = '0;
          for (int i = 0; i < MaxVertices; i++) rows_d[i] = '0;
          ok_d = 1'b1;
        end
        CMD_CLR_VEDGES: begin
          if (present_q[f_q]) begin
            rows_d[f_q] = '0;
            ok_d = 1'b1;
          end
        end
        CMD_CLR_EDGES: begin
          for (int i = 0; i < MaxVertices; i++) rows_d[i] = '0;
          ok_d = 1'b1;
        end
        CMD_TEST_VERTEX: ok_d = present_q[f_q];
        default: ok_d = 1'b0;
      endcase
      if (add_fail_now && rev_d) begin
        rows_d[f_q][t_q] = 1'b1;
      end
    end else if (cmd_i.peel_init) begin
      // Candidate edge goes in for the duration of the test.
      rows_d[af_q][at_q] = 1'b1;
      marked_d = '0;
    end else if (cmd_i.peel_step) begin
      if (peel_found) marked_d[peel_v] = 1'b1;
    end else if (cmd_i.finish) begin
      if ((marked_q & present_q) == present_q) begin
        ok_d = 1'b1;
      end else begin
        rows_d[af_q][at_q] = 1'b0;
        if (rev_q) rows_d[at_q][af_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      marked_q <= '0;
      pend_q <= 1'b0;
      rev_q <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) rows_q[i] <= '0;
    end else begin
      present_q <= present_d;
      marked_q <= marked_d;
      pend_q <= pend_d;
      rev_q <= rev_d;
      rows_q <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      f_q <= from_vertex_i;
      t_q <= to_vertex_i;
    end
    af_q <= af_d;
    at_q <= at_d;
    ok_q <= ok_d;
    nv_q <= nv_d;
  end

  assign sts_o.need_peel = pend_q;
  assign sts_o.peel_done = peel_done;
  assign ok_o = ok_q;
  assign new_vertex_o = nv_q;
endmodule

[rtl/des_ctrl.sv]
// Controller of the graph edge store: handshake and command sequencing.
module des_ctrl
  import des_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  des_sts_t sts_i,
  output des_cmd_t cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StPeel = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load = accept;
        if (accept) state_d = StExec;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (sts_i.need_peel) begin
          cmd_o.peel_init = 1'b1;
          state_d = StPeel;
        end else begin
          state_d = StOut;
        end
      end
      StPeel: begin
        if (sts_i.peel_done) begin
          state_d = StFin;
        end else begin
          cmd_o.peel_step = 1'b1;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[rtl/dag_edge_store_with_cycle_check.sv]
// Top level of the directed graph edge store with its acyclic check.
// This block keeps a directed graph of up to 16 vertices (presence mask and
// a 16x16 adjacency matrix) and runs one command item at a time. An item is
// taken, executed and its result item held until the output side takes it;
// the next item is accepted only after that. A simple command passes through
// the execute and check states before its result item is valid. An edge add
// (or the add half of a reverse) in acyclic mode whose edge checks pass also
// runs the peel unit, which marks one vertex whose targets are all marked per
// cycle, then sees that nothing is left to mark, and then commits or undoes
// the edge before the result is valid. Configuration registers are written
// through a plain write port and must only change while no item is in work.
module dag_edge_store_with_cycle_check
  import des_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [3:0]      command_i,
  input  logic [VidW-1:0] from_vertex_i,
  input  logic [VidW-1:0] to_vertex_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            ok_o,
  output logic [VidW-1:0] new_vertex_o
);
  localparam logic RegAcyclic = 1'b0;
  localparam logic RegMaxOut  = 1'b1;

  logic            acyclic_q;
  logic [CntW-1:0] max_out_q;
  des_cmd_t        cmd;
  des_sts_t        sts;

  // Only two registers exist, so the index port is one bit wide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acyclic_q <= 1'b1;
      max_out_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAcyclic: acyclic_q <= cfg_wdata_i[0];
        RegMaxOut:  max_out_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  des_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  des_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .command_i, .from_vertex_i,
    .to_vertex_i, .acyclic_only_i(acyclic_q), .max_out_edges_i(max_out_q),
    .ok_o, .new_vertex_o
  );
endmodule

[rtl/des_checker.sv]
// Port-level checker for the graph edge store, bound to the top level.
`include "dag_edge_store_with_cycle_check_assert.svh"
module des_checker
  import des_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            ok_o,
  input logic [VidW-1:0] new_vertex_o
);
  // One item in work at a time: no input is taken while a result waits.
  `DES_ASSERT_IMP(a_no_take_with_result, clk_i, rst_ni, out_valid_o, in_stall_o)
  // A result held under stall keeps its value.
  `DES_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(ok_o) && $stable(new_vertex_o))
  // A new vertex id is only reported with success.
  `DES_ASSERT_IMP(a_nv_ok, clk_i, rst_ni, out_valid_o && new_vertex_o != '0, ok_o)
  // After an accepted item the block is busy in the next cycle.
  `DES_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind dag_edge_store_with_cycle_check des_checker u_des_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .ok_o, .new_vertex_o
);

[sim/graph_cmd_checker.sv]
// Checker that predicts and compares the results of the graph edge store.
`timescale 1ns / 100ps
module graph_cmd_checker
  import des_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_stall_o,
  input  logic [3:0]      command_i,
  input  logic [VidW-1:0] from_vertex_i,
  input  logic [VidW-1:0] to_vertex_i,
  input  logic            out_valid_o,
  input  logic            out_stall_i,
  input  logic            ok_o,
  input  logic [VidW-1:0] new_vertex_o,
  output int              fail_count,
  output int              pending_count
);
  typedef struct packed {
    logic            ok;
    logic [VidW-1:0] nv;
  } answer_t;

  answer_t answer_q[$];
  logic       acyc;
  logic [4:0] out_limit;
  row_t       present;
  row_t       rows [MaxVertices];

  assign pending_count = answer_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic bit has(input logic [VidW-1:0] v);
    return present[v];
  endfunction

  function automatic bit acyclic_now();
    row_t marked;
    bit   found;
    marked = '0;
    for (int r = 0; r < MaxVertices; r++) begin
      found = 0;
      for (int v = 0; v < MaxVertices; v++) begin
        if (!found && present[v] && !marked[v] && (rows[v] & ~marked) == '0) begin
          marked[v] = 1'b1;
          found = 1;
        end
      end
      if (!found) break;
    end
    return (marked & present) == present;
  endfunction

  function automatic bit link(input logic [VidW-1:0] f, input logic [VidW-1:0] t);
    bit good;
    if (!has(f) || !has(t)) return 0;
    if (out_limit != 0 && $countones(rows[f]) >= out_limit) return 0;
    if (rows[f][t]) return 0;
    if (acyc) begin
      if (f == t) return 0;
      rows[f][t] = 1'b1;
      good = acyclic_now();
      rows[f][t] = 1'b0;
      if (!good) return 0;
    end
    rows[f][t] = 1'b1;
    return 1;
  endfunction

  function automatic bit unlink(input logic [VidW-1:0] f, input logic [VidW-1:0] t);
    if (!has(f) || !has(t) || !rows[f][t]) return 0;
    rows[f][t] = 1'b0;
    return 1;
  endfunction

  function automatic answer_t run_command(input logic [3:0] c, input logic [VidW-1:0] f,
                                          input logic [VidW-1:0] t);
    answer_t a;
    int      id;
    a = '0;
    case (c)
      CMD_ADD_VERTEX: begin
        id = 0;
        for (int i = MaxVertices - 1; i >= 0; i--) begin
          if (present[i]) begin
            id = i + 1;
            break;
          end
        end
        if (id < MaxVertices) begin
          present[id] = 1'b1;
          rows[id] = '0;
          a.ok = 1'b1;
          a.nv = id[VidW-1:0];
        end
      end
      CMD_DEL_VERTEX: if (has(f)) begin
        for (int i = 0; i < MaxVertices; i++) rows[i][f] = 1'b0;
        rows[f] = '0;
        present[f] = 1'b0;
        a.ok = 1'b1;
      end
      CMD_ADD_EDGE: a.ok = link(f, t);
      CMD_DEL_EDGE: a.ok = unlink(f, t);
      CMD_REV_EDGE: if (unlink(f, t)) begin
        if (link(t, f)) a.ok = 1'b1;
        else rows[f][t] = 1'b1;
      end
      CMD_CLEAR: begin
        present = '0;
        foreach (rows[i]) rows[i] = '0;
        a.ok = 1'b1;
      end
      CMD_CLR_VEDGES: if (has(f)) begin
        rows[f] = '0;
        a.ok = 1'b1;
      end
      CMD_CLR_EDGES: begin
        foreach (rows[i]) rows[i] = '0;
        a.ok = 1'b1;
      end
      CMD_TEST_VERTEX: a.ok = has(f);
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      acyc = 1'b1;
      out_limit = '0;
      present = '0;
      foreach (rows[i]) rows[i] = '0;
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == 1'b0) acyc = cfg_wdata_i[0];
        else out_limit = cfg_wdata_i;
      end
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = answer_q.pop_front();
          if (ok_o !== want.ok)
            report($sformatf("ok got %b want %b", ok_o, want.ok));
          if (new_vertex_o !== want.nv)
            report($sformatf("new_vertex got %0d want %0d", new_vertex_o, want.nv));
        end
      end
      if (in_valid_i && !in_stall_o)
        answer_q.insert(answer_q.size(),
                        run_command(command_i, from_vertex_i, to_vertex_i));
    end
  end
endmodule

[sim/tb.sv]
// Top of the testbench: stimulus, configuration phases and the verdict.
`timescale 1ns / 100ps
module tb;
  import des_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_index_i = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [3:0]      command_i = '0;
  logic [VidW-1:0] from_vertex_i = '0;
  logic [VidW-1:0] to_vertex_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            ok_o;
  logic [VidW-1:0] new_vertex_o;
  int              fail_count;
  int              pending_count;
  int              cycle_count = 0;
  // When set, the receiver holds off for a long stretch.
  bit              hold_off = 0;

  localparam int CycleLimit = 600000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  dag_edge_store_with_cycle_check u_dut (.*);

  graph_cmd_checker u_chk (.*);

  // The run is cut off if the block hangs anywhere.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a random stall before each result item, with stretches of
  // none, and one long hold-off while the sender keeps offering items.
  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  // Offer one item and hold it until the block takes it; the valid line is
  // left high so that back-to-back items never drop it within one step.
  task automatic send_item(input logic [3:0] c, input logic [VidW-1:0] f,
                           input logic [VidW-1:0] t, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    from_vertex_i <= f;
    to_vertex_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    // Every item causes a result, so only a short settle is needed.
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CntW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Mostly vertex adds and edge work on ids up to hi so that the graph
  // grows dense; the rest is any command including the unused codes.
  task automatic random_item(input int hi);
    int   r;
    logic [3:0] c;
    r = $urandom_range(0, 99);
    if (r < 12) c = CMD_ADD_VERTEX;
    else if (r < 45) c = CMD_ADD_EDGE;
    else if (r < 55) c = CMD_REV_EDGE;
    else if (r < 63) c = CMD_DEL_EDGE;
    else if (r < 68) c = CMD_DEL_VERTEX;
    else if (r < 73) c = CMD_TEST_VERTEX;
    else if (r < 76) c = CMD_CLR_VEDGES;
    else if (r < 77) c = CMD_CLR_EDGES;
    else if (r < 78) c = CMD_CLEAR;
    else c = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0)
      send_item(c, VidW'($urandom_range(0, 15)), VidW'($urandom_range(0, 15)),
                draw_gap());
    else
      send_item(c, VidW'($urandom_range(0, hi)), VidW'($urandom_range(0, hi)),
                draw_gap());
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: empty-graph failures, filling
    // every id until the add fails, a cycle refusal, a self-loop refusal,
    // a reverse that succeeds, then the clear commands and an unused code.
    send_item(CMD_TEST_VERTEX, 4'd15, 4'd0, 0);
    send_item(CMD_DEL_VERTEX, 4'd0, 4'd0, 0);
    send_item(CMD_CLR_VEDGES, 4'd3, 4'd0, 0);
    for (int i = 0; i < 17; i++) send_item(CMD_ADD_VERTEX, 4'd0, 4'd0, 0);
    send_item(CMD_ADD_EDGE, 4'd0, 4'd15, 0);
    send_item(CMD_ADD_EDGE, 4'd15, 4'd0, 0);
    send_item(CMD_ADD_EDGE, 4'd5, 4'd5, 0);
    send_item(CMD_ADD_EDGE, 4'd15, 4'd7, 0);
    send_item(CMD_REV_EDGE, 4'd0, 4'd15, 0);
    send_item(CMD_DEL_VERTEX, 4'd15, 4'd0, 0);
    send_item(CMD_ADD_VERTEX, 4'd0, 4'd0, 0);
    send_item(CMD_CLR_EDGES, 4'd0, 4'd0, 0);
    send_item(4'd15, 4'd15, 4'd15, 0);
    send_item(CMD_CLEAR, 4'd0, 4'd0, 0);
    drain_results();

    // Random phases across the settings, including both extremes of the
    // out-degree limit and cyclic mode. Each phase ends in a pause
    // until every expected result has come.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(1'b0, 5'd1); write_reg(1'b1, 5'd0); end
        1: begin write_reg(1'b0, 5'd0); write_reg(1'b1, 5'd16); end
        2: begin write_reg(1'b0, 5'd1); write_reg(1'b1, 5'd1); end
        3: begin write_reg(1'b0, 5'd0); write_reg(1'b1, 5'd2); end
        4: begin write_reg(1'b0, 5'd1); write_reg(1'b1, 5'd31); end
        default: begin write_reg(1'b0, 5'd1); write_reg(1'b1, 5'd3); end
      endcase
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 150; n++) random_item(ph[0] ? 15 : 7);
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[dag_edge_store_with_cycle_check.f]
+incdir+rtl
rtl/des_pkg.sv
rtl/des_datapath.sv
rtl/des_ctrl.sv
rtl/dag_edge_store_with_cycle_check.sv
rtl/des_checker.sv
sim/graph_cmd_checker.sv
sim/tb.sv
